[design/refracted_direction_snell_assert.svh]
// Assertion macros for the refraction pipeline.
`ifndef REFRACTED_DIRECTION_SNELL_ASSERT_SVH
`define REFRACTED_DIRECTION_SNELL_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RDS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define RDS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[design/rds_pkg.sv]
// Package with word types, cell state types and saturation helpers.
`timescale 1ns / 1ps
`default_nettype none
package rds_pkg;

    localparam int RatioBits = 20;
    localparam int DivCells  = RatioBits;
    localparam int SqrtCells = 16;

    typedef struct packed {
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
        logic [15:0]        ior_origin;
        logic [15:0]        ior_destination;
    } t_in_word;

    typedef struct packed {
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
        logic signed [15:0] out_z;
        logic               total_internal_reflection;
    } t_out_word;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               entering;
    } t_side;

    typedef struct packed {
        logic [15:0]          rem;
        logic [15:0]          den;
        logic [RatioBits-1:0] quo;
        logic [RatioBits-1:0] low;
        logic                 sat;
        t_side                side;
    } t_div_st;

    typedef struct packed {
        logic signed [15:0] ox;
        logic signed [15:0] oy;
        logic signed [15:0] z;
        logic               entering;
        logic               tir;
    } t_fin;

    typedef struct packed {
        logic [16:0] rem;
        logic [15:0] root;
        logic [31:0] rad;
        t_fin        fin;
    } t_sq_st;

    function automatic logic signed [15:0] neg_sat16(input logic signed [15:0] v);
        logic signed [16:0] n;
        n = -{v[15], v};
        return (n > 17'sd32767) ? 16'sh7fff : n[15:0];
    endfunction

    function automatic logic signed [15:0] sat22(input logic signed [21:0] v);
        if (v > 22'sd32767) begin
            return 16'sh7fff;
        end else if (v < -22'sd32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

endpackage
`default_nettype wire

[design/refracted_direction_snell.sv]
// Top level of the Snell refraction pipeline with total internal reflection.
// Pipeline: 20 division cells, two multiply stages, 16 square root cells and one
// output register lie between an accepted word and its result word.
// Throughput: one word per cycle; the whole chain holds while a result waits.
// Reset: synchronous, active low; clears every valid bit, payload is not reset.
`timescale 1ns / 1ps
`default_nettype none
module refracted_direction_snell (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire rds_pkg::t_in_word i_word,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output rds_pkg::t_out_word     o_word
);
    import rds_pkg::*;

    `include "refracted_direction_snell_assert.svh"

    // The chain advances whenever the output register is free or being drained.
    logic en;
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    // Entry: pick the index order and seed the divider. The quotient fits in
    // 20 bits exactly when the numerator is below sixteen times the divisor;
    // otherwise, and for a zero divisor, the ratio saturates.
    logic [15:0] num;
    logic [15:0] den;
    logic        entering;
    t_div_st     dd [0:DivCells];
    logic        dv [0:DivCells];

    always_comb begin
        entering = i_word.dir_z > 16'sd0;
        num = entering ? i_word.ior_origin : i_word.ior_destination;
        den = entering ? i_word.ior_destination : i_word.ior_origin;
        dd[0].rem  = {4'b0, num[15:4]};
        dd[0].den  = den;
        dd[0].quo  = '0;
        dd[0].low  = {num[3:0], 16'b0};
        dd[0].sat  = (den == 16'd0) || ({4'b0, num} >= {den, 4'b0});
        dd[0].side = '{x: i_word.dir_x, y: i_word.dir_y, z: i_word.dir_z,
                       entering: entering};
        dv[0] = i_valid;
    end

    for (genvar g = 0; g < DivCells; g++) begin : g_div
        rds_div_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_v    (dv[g]),
            .i_d    (dd[g]),
            .o_v    (dv[g+1]),
            .o_d    (dd[g+1])
        );
    end

    // First multiply stage: the squared ratio, one minus z squared, and the
    // ratio times x and y, all in parallel.
    logic [RatioBits-1:0] ratio;
    logic [39:0]          ratio_sq;
    logic signed [31:0]   z_sq;
    logic signed [31:0]   one_minus;
    logic signed [36:0]   rx;
    logic signed [36:0]   ry;

    always_comb begin
        ratio     = dd[DivCells].sat ? '1 : dd[DivCells].quo;
        ratio_sq  = 40'(ratio) * 40'(ratio);
        z_sq      = 32'(dd[DivCells].side.z) * 32'(dd[DivCells].side.z);
        one_minus = 32'sh4000_0000 - z_sq;
        rx = $signed({17'b0, ratio}) * 37'(dd[DivCells].side.x);
        ry = $signed({17'b0, ratio}) * 37'(dd[DivCells].side.y);
    end

    logic               r_m1_v;
    logic [31:0]        r_rsq;
    logic [15:0]        r_om;
    logic signed [36:0] r_rx;
    logic signed [36:0] r_ry;
    t_side              r_m1_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_v <= 1'b0;
        end else if (en) begin
            r_m1_v <= dv[DivCells];
        end
        if (en) begin
            r_rsq     <= ratio_sq[39:8];
            r_om      <= one_minus[30:15];
            r_rx      <= rx;
            r_ry      <= ry;
            r_m1_side <= dd[DivCells].side;
        end
    end

    // Second multiply stage: the scaled product and the negated, floored and
    // saturated refracted x and y.
    logic [47:0]        prod;
    logic signed [37:0] nx;
    logic signed [37:0] ny;
    logic signed [37:0] nx_sh;
    logic signed [37:0] ny_sh;

    always_comb begin
        prod  = 48'(r_rsq) * 48'(r_om);
        nx    = -{r_rx[36], r_rx};
        ny    = -{r_ry[36], r_ry};
        nx_sh = nx >>> 16;
        ny_sh = ny >>> 16;
    end

    logic               r_m2_v;
    logic [23:0]        r_prod;
    logic signed [15:0] r_rox;
    logic signed [15:0] r_roy;
    t_side              r_m2_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m2_v <= 1'b0;
        end else if (en) begin
            r_m2_v <= r_m1_v;
        end
        if (en) begin
            r_prod    <= prod[47:24];
            r_rox     <= sat22(nx_sh[21:0]);
            r_roy     <= sat22(ny_sh[21:0]);
            r_m2_side <= r_m1_side;
        end
    end

    // Critical term and the reflection decision; seeds the square root chain.
    logic signed [24:0] critical;
    logic               tir;
    t_sq_st             sd [0:SqrtCells];
    logic               sv [0:SqrtCells];

    always_comb begin
        critical = 25'sd32768 - $signed({1'b0, r_prod});
        tir      = critical[24];
        sd[0].rem  = '0;
        sd[0].root = '0;
        sd[0].rad  = {1'b0, critical[15:0], 15'b0};
        sd[0].fin.ox       = tir ? neg_sat16(r_m2_side.x) : r_rox;
        sd[0].fin.oy       = tir ? neg_sat16(r_m2_side.y) : r_roy;
        sd[0].fin.z        = r_m2_side.z;
        sd[0].fin.entering = r_m2_side.entering;
        sd[0].fin.tir      = tir;
        sv[0] = r_m2_v;
    end

    for (genvar g = 0; g < SqrtCells; g++) begin : g_sqrt
        rds_sqrt_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_v    (sv[g]),
            .i_d    (sd[g]),
            .o_v    (sv[g+1]),
            .o_d    (sd[g+1])
        );
    end

    // Output: the root takes the sign of the side the ray leaves towards; a
    // positive root of exactly one saturates.
    logic [15:0]        root;
    logic signed [16:0] neg_root;
    t_fin               fin;
    t_out_word          n_out;
    logic               r_out_v;
    t_out_word          r_out;

    always_comb begin
        root     = sd[SqrtCells].root;
        fin      = sd[SqrtCells].fin;
        neg_root = -$signed({1'b0, root});
        n_out.out_x = fin.ox;
        n_out.out_y = fin.oy;
        n_out.total_internal_reflection = fin.tir;
        if (fin.tir) begin
            n_out.out_z = fin.z;
        end else if (fin.entering) begin
            n_out.out_z = neg_root[15:0];
        end else begin
            n_out.out_z = root[15] ? 16'sh7fff : $signed(root);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= sv[SqrtCells];
        end
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_v;
    assign o_word  = r_out;

    // The input side is only held back while a finished word waits.
    `RDS_ASSERT_NOW(a_stall_only_when_full, o_stall, o_valid && i_stall)
    // A refracted ray that enters the surface never leaves with a positive z.
    `RDS_ASSERT_NOW(a_enter_z_sign, sv[SqrtCells] && !fin.tir && fin.entering,
        n_out.out_z <= 16'sd0)
    // Reflection is flagged exactly when the critical term is negative.
    `RDS_ASSERT_NEXT(a_tir_from_critical, en && r_m2_v,
        sd[1].fin.tir == $past(critical < 25'sd0))
endmodule
`default_nettype wire

[design/rds_div_cell.sv]
// One restoring division cell: resolves one ratio bit per cycle while i_en is high.
`timescale 1ns / 1ps
`default_nettype none
module rds_div_cell (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_v,
    input  wire rds_pkg::t_div_st i_d,
    output logic                  o_v,
    output rds_pkg::t_div_st      o_d
);
    import rds_pkg::*;

    logic    r_v;
    t_div_st r_d;
    t_div_st n_d;
    logic [16:0] trial;
    logic [16:0] diff;
    logic        ge;

    always_comb begin
        trial = {i_d.rem, i_d.low[RatioBits-1]};
        ge    = trial >= {1'b0, i_d.den};
        diff  = trial - {1'b0, i_d.den};
        n_d     = i_d;
        n_d.rem = ge ? diff[15:0] : trial[15:0];
        n_d.quo = {i_d.quo[RatioBits-2:0], ge};
        n_d.low = {i_d.low[RatioBits-2:0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_v;
        end
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_v = r_v;
    assign o_d = r_d;
endmodule
`default_nettype wire

[design/rds_sqrt_cell.sv]
// One integer square root cell: resolves one root bit per cycle while i_en is high.
`timescale 1ns / 1ps
`default_nettype none
module rds_sqrt_cell (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_v,
    input  wire rds_pkg::t_sq_st i_d,
    output logic                 o_v,
    output rds_pkg::t_sq_st      o_d
);
    import rds_pkg::*;

    logic   r_v;
    t_sq_st r_d;
    t_sq_st n_d;
    logic [18:0] acc;
    logic [18:0] trial;
    logic [18:0] diff;
    logic        ge;

    always_comb begin
        acc   = {i_d.rem, i_d.rad[31:30]};
        trial = {1'b0, i_d.root, 2'b01};
        ge    = acc >= trial;
        diff  = acc - trial;
        n_d      = i_d;
        n_d.rem  = ge ? diff[16:0] : acc[16:0];
        n_d.root = {i_d.root[14:0], ge};
        n_d.rad  = {i_d.rad[29:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_v;
        end
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_v = r_v;
    assign o_d = r_d;
endmodule
`default_nettype wire
